// File: hw/rtl/wfs_pkg.sv
// Package for the winnowing fingerprint selector: widths, defaults, config codes,
// controller state type, command/status structs and djb2 power helpers.
// No dependencies.
package wfs_pkg;

    // Default parameter values
    localparam int SHRED_BYTES_DEF      = 16;
    localparam int WINDOW_MAX_DEF       = 16;
    localparam int FINGERPRINT_BITS_DEF = 18;

    // Fixed field widths
    localparam int BYTE_W      = 8;
    localparam int HASH_W      = 32;
    localparam int OFFSET_W    = 32;
    localparam int WIN_CFG_W   = 5;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;

    localparam logic [HASH_W-1:0] DJB_SEED = 32'd5381;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIZE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDRESS = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_STORE,
        ST_DECIDE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;         // input transfer: latch byte, shift history
        logic roll;         // rolling hash update
        logic store;        // write shred hash into window ring
        logic take_new;     // newest hash becomes the minimum
        logic scan_start;   // set up a window rescan
        logic scan_run;     // rescan in progress
        logic scan_commit;  // rescan result becomes the minimum
        logic emit;         // load output register
        logic finish;       // item done
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic have_shred;
        logic full_win;
        logic need_scan;
        logic hash_le;
        logic scan_done;
        logic out_free;
    } t_status;

    // 33^n modulo 2^32, elaboration time only
    function automatic logic [HASH_W-1:0] pow33(input int n);
        logic [HASH_W-1:0] r;
        int k;
        r = 32'd1;
        for (k = 0; k < n; k++) begin
            r = r * 32'd33;
        end
        return r;
    endfunction

    // Hash of an all-zero shred: seed * 33^n modulo 2^32
    function automatic logic [HASH_W-1:0] seed_term(input int n);
        logic [HASH_W-1:0] r;
        r = DJB_SEED * pow33(n);
        return r;
    endfunction

endpackage

// File: hw/rtl/winnowing_fingerprint_selector_unit.sv
// Winnowing fingerprint selector, top level. Each item is hashed; once a shred exists it
// is also stored and decided; a minimum update adds an emit step; a rescan reads the
// effective window (1 to WINDOW_MAX) through the single read port of the hash ring and
// then emits. One item at a time; a result waits in the output register while the next
// byte is taken, and an emit stalls until that register is free.
// Sync active-low reset clears section state, window_size 1, base_address 0; ring kept.
module winnowing_fingerprint_selector_unit #(
    parameter int SHRED_BYTES      = wfs_pkg::SHRED_BYTES_DEF,
    parameter int WINDOW_MAX       = wfs_pkg::WINDOW_MAX_DEF,
    parameter int FINGERPRINT_BITS = wfs_pkg::FINGERPRINT_BITS_DEF,
    localparam int M_TDATA_W = ((wfs_pkg::OFFSET_W + FINGERPRINT_BITS + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream: tdata = data_byte[7:0]; tlast = last
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [wfs_pkg::BYTE_W-1:0]       i_s_tdata,
    input  logic                             i_s_tlast,
    // output stream: tdata = feature_offset[31:0], feature_hash, zero pad
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [M_TDATA_W-1:0]             o_m_tdata,
    // config write: index 0 window_size, 1 base_address
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [wfs_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [wfs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import wfs_pkg::*;

    t_cmd                        cmd;
    t_status                     status;
    logic [OFFSET_W-1:0]         feature_offset;
    logic [FINGERPRINT_BITS-1:0] feature_hash;

    wfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    wfs_datapath #(
        .SHRED_BYTES      (SHRED_BYTES),
        .WINDOW_MAX       (WINDOW_MAX),
        .FINGERPRINT_BITS (FINGERPRINT_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_data_byte      (i_s_tdata),
        .i_last           (i_s_tlast),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_out_ready      (i_m_tready),
        .o_out_valid      (o_m_tvalid),
        .o_feature_offset (feature_offset),
        .o_feature_hash   (feature_hash),
        .i_cmd            (cmd),
        .o_status         (status)
    );

    // Pack result fields, offset in the low bits
    assign o_m_tdata = M_TDATA_W'({feature_hash, feature_offset});

    // Output register is only loaded when its previous result is gone
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_m_tvalid || i_m_tready))
        else $error("result loaded over a pending result");

    // No datapath step runs while a byte can be taken
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !(cmd.roll || cmd.store || cmd.scan_run || cmd.emit))
        else $error("datapath busy while input ready");

    // An accepted byte is hashed in the next cycle
    a_load_roll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> cmd.roll)
        else $error("accepted byte not hashed");

    // A rescan setup is followed by the scan itself
    a_scan_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scan_start |=> (cmd.scan_run && !status.scan_done))
        else $error("rescan did not start");

endmodule

// File: hw/rtl/wfs_ctrl.sv
// Controller state machine of the winnowing fingerprint selector.
// Sequences hash, store, decide, rescan and emit steps. Depends on wfs_pkg.
module wfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  wfs_pkg::t_status  i_status,
    output wfs_pkg::t_cmd     o_cmd
);
    import wfs_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_HASH;
            end
            ST_HASH: begin
                n_state = i_status.have_shred ? ST_STORE : ST_IDLE;
            end
            ST_STORE: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!i_status.full_win)      n_state = ST_IDLE;
                else if (i_status.need_scan) n_state = ST_SCAN;
                else if (i_status.hash_le)   n_state = ST_EMIT;
                else                         n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (i_status.scan_done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_HASH: begin
                o_cmd.roll   = 1'b1;
                o_cmd.finish = !i_status.have_shred;
            end
            ST_STORE: begin
                o_cmd.store = 1'b1;
            end
            ST_DECIDE: begin
                o_cmd.scan_start = i_status.full_win && i_status.need_scan;
                o_cmd.take_new   = i_status.full_win && !i_status.need_scan
                                   && i_status.hash_le;
                o_cmd.finish     = !i_status.full_win
                                   || (!i_status.need_scan && !i_status.hash_le);
            end
            ST_SCAN: begin
                o_cmd.scan_run    = 1'b1;
                o_cmd.scan_commit = i_status.scan_done;
            end
            ST_EMIT: begin
                o_cmd.emit   = i_status.out_free;
                o_cmd.finish = i_status.out_free;
            end
            default: ;
        endcase
    end

endmodule

// File: hw/rtl/wfs_datapath.sv
// Datapath of the winnowing fingerprint selector: byte history, rolling djb2 hash,
// hash window ring memory, minimum tracking, rescan unit, config and output registers.
// Depends on wfs_pkg.
module wfs_datapath #(
    parameter int SHRED_BYTES      = wfs_pkg::SHRED_BYTES_DEF,
    parameter int WINDOW_MAX       = wfs_pkg::WINDOW_MAX_DEF,
    parameter int FINGERPRINT_BITS = wfs_pkg::FINGERPRINT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [wfs_pkg::BYTE_W-1:0]         i_data_byte,
    input  logic                               i_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [wfs_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [wfs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [wfs_pkg::OFFSET_W-1:0]       o_feature_offset,
    output logic [FINGERPRINT_BITS-1:0]        o_feature_hash,
    input  wfs_pkg::t_cmd                      i_cmd,
    output wfs_pkg::t_status                   o_status
);
    import wfs_pkg::*;

    localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int WIN_W = $clog2(WINDOW_MAX + 1);
    localparam int IW    = WIN_W + 1;
    localparam logic [HASH_W-1:0] TOP_POW   = pow33(SHRED_BYTES - 1);
    localparam logic [HASH_W-1:0] SEED_TERM = seed_term(SHRED_BYTES);

    // Configuration
    logic [WIN_CFG_W-1:0] r_win_size;
    logic [OFFSET_W-1:0]  r_base;

    // Section state
    logic [BYTE_W-1:0]   r_hist [SHRED_BYTES];  // index 0 newest
    logic [HASH_W-1:0]   r_sum;                 // weighted byte sum, hash = seed term + sum
    logic [HASH_W-1:0]   r_count;
    logic [PTR_W-1:0]    r_ptr;                 // ring slot of next shred
    logic [HASH_W-1:0]   r_min_hash;
    logic [OFFSET_W-1:0] r_min_pos;
    logic                r_min_valid;
    logic                r_last;

    // Per-item payload
    logic [BYTE_W-1:0]   r_byte;
    logic [HASH_W-1:0]   r_prod;
    logic [HASH_W-1:0]   r_hash;
    logic [OFFSET_W-1:0] r_s;
    logic [PTR_W-1:0]    r_wptr;

    // Rescan unit
    logic [HASH_W-1:0]   r_mem [WINDOW_MAX];
    logic [HASH_W-1:0]   r_rdata;
    logic [PTR_W-1:0]    r_addr;
    logic [OFFSET_W-1:0] r_pos;
    logic [OFFSET_W-1:0] r_rpos;
    logic [WIN_W-1:0]    r_cnt;
    logic                r_rv;
    logic                r_first;
    logic [HASH_W-1:0]   r_best;
    logic [OFFSET_W-1:0] r_best_pos;

    // Output register
    logic                        r_out_valid;
    logic [OFFSET_W-1:0]         r_off;
    logic [FINGERPRINT_BITS-1:0] r_fp;

    logic [HASH_W-1:0]   diff;
    logic [HASH_W-1:0]   n_sum;
    logic [HASH_W-1:0]   hash_now;
    logic [PTR_W-1:0]    n_ptr;
    logic [WIN_W-1:0]    weff;
    logic [WIN_W-1:0]    wm1;
    logic [OFFSET_W-1:0] start;
    logic [IW-1:0]       start_sum;
    logic [PTR_W-1:0]    start_slot;
    logic                sec_clear;
    logic                out_free;

    assign o_cfg_ready = 1'b1;

    // Config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size <= WIN_CFG_W'(1);
            r_base     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW_SIZE:  r_win_size <= i_cfg_data[WIN_CFG_W-1:0];
                CFG_BASE_ADDRESS: r_base     <= i_cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective window: zero acts as one, clamp to ring depth
    always_comb begin
        if (r_win_size == '0)                   weff = WIN_W'(1);
        else if (int'(r_win_size) > WINDOW_MAX) weff = WIN_W'(WINDOW_MAX);
        else                                    weff = WIN_W'(r_win_size);
    end
    assign wm1 = weff - WIN_W'(1);

    // Rolling djb2: drop oldest byte weight, times 33, add newest
    assign diff     = r_sum - r_prod;
    assign n_sum    = (diff << 5) + diff + HASH_W'(r_byte);
    assign hash_now = SEED_TERM + r_sum;
    assign n_ptr    = (r_ptr == PTR_W'(WINDOW_MAX - 1)) ? '0 : r_ptr + PTR_W'(1);

    // Window start and its ring slot
    assign start     = r_s - OFFSET_W'(wm1);
    assign start_sum = IW'(r_wptr) + IW'(WINDOW_MAX) - IW'(wm1);
    assign start_slot = (start_sum >= IW'(WINDOW_MAX)) ?
                        PTR_W'(start_sum - IW'(WINDOW_MAX)) : PTR_W'(start_sum);

    assign sec_clear = i_cmd.finish && r_last;
    assign out_free  = !r_out_valid || i_out_ready;

    // Section state, cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || sec_clear) begin
            for (int k = 0; k < SHRED_BYTES; k++) r_hist[k] <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_ptr       <= '0;
            r_min_hash  <= '0;
            r_min_pos   <= '0;
            r_min_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_hist[0] <= i_data_byte;
                for (int k = 1; k < SHRED_BYTES; k++) r_hist[k] <= r_hist[k-1];
                r_count <= r_count + HASH_W'(1);
                r_last  <= i_last;
                // count wrap restarts the ring slot at zero
                if (r_count == '1) r_ptr <= '0;
            end
            if (i_cmd.roll) r_sum <= n_sum;
            if (i_cmd.store) r_ptr <= n_ptr;
            if (i_cmd.take_new) begin
                r_min_hash <= r_hash;
                r_min_pos  <= r_s;
            end
            if (i_cmd.scan_commit) begin
                r_min_hash  <= r_best;
                r_min_pos   <= r_best_pos;
                r_min_valid <= 1'b1;
            end
        end
    end

    // Per-item payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_data_byte;
            r_prod <= HASH_W'(r_hist[SHRED_BYTES-1]) * TOP_POW;
        end
        if (i_cmd.store) begin
            r_hash <= hash_now;
            r_s    <= r_count - OFFSET_W'(SHRED_BYTES);
            r_wptr <= r_ptr;
        end
    end

    // Hash window ring memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) r_mem[r_ptr] <= hash_now;
        if (i_cmd.scan_run && r_cnt != '0) r_rdata <= r_mem[r_addr];
    end

    // Rescan control: one read issued per cycle, compared the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_rv    <= 1'b0;
            r_first <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_cnt   <= weff;
            r_rv    <= 1'b0;
            r_first <= 1'b1;
        end else if (i_cmd.scan_run) begin
            r_rv <= (r_cnt != '0);
            if (r_cnt != '0) r_cnt <= r_cnt - WIN_W'(1);
            if (r_rv) r_first <= 1'b0;
        end
    end

    // Rescan payload: address walk and rightmost minimum
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_addr <= start_slot;
            r_pos  <= start;
        end else if (i_cmd.scan_run) begin
            if (r_cnt != '0) begin
                r_addr <= (r_addr == PTR_W'(WINDOW_MAX - 1)) ? '0 : r_addr + PTR_W'(1);
                r_pos  <= r_pos + OFFSET_W'(1);
            end
            r_rpos <= r_pos;
            if (r_rv && (r_first || r_rdata <= r_best)) begin
                r_best     <= r_rdata;
                r_best_pos <= r_rpos;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_off <= r_base + r_min_pos;
            r_fp  <= r_min_hash[FINGERPRINT_BITS-1:0];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_feature_offset = r_off;
    assign o_feature_hash   = r_fp;

    // Status to controller
    assign o_status.have_shred = (r_count >= HASH_W'(SHRED_BYTES));
    assign o_status.full_win   = (r_s >= OFFSET_W'(wm1));
    assign o_status.need_scan  = !r_min_valid || (r_min_pos < start);
    assign o_status.hash_le    = (r_hash <= r_min_hash);
    assign o_status.scan_done  = (r_cnt == '0) && !r_rv;
    assign o_status.out_free   = out_free;

endmodule
